// ----- rtl/cq_pkg.sv -----
// Package for the circular queue: sizes, request codes and the word types of both channels.
// Used by circular_queue, cq_ctrl and cq_dp; it depends on nothing.
package cq_pkg;

   localparam int DEPTH  = 16;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CAP_W  = $clog2(DEPTH + 1);
   localparam int CFG_W  = 5;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 2;

   localparam logic [1:0] KIND_ENQ   = 2'd0;
   localparam logic [1:0] KIND_DEQ   = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   localparam logic [ADDR_W-1:0] REG_CAPACITY = ADDR_W'(0);

   typedef struct packed {
      logic [1:0]               kind;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     accepted;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] rear_value;
      logic                     is_empty;
      logic                     is_full;
   } rsp_type;

   typedef struct packed {
      logic exec;
      logic rd;
      logic rsp;
   } cmd_type;

endpackage

// ----- rtl/circular_queue.sv -----
// Top level of the circular queue: register port, controller and datapath.
// Depends on cq_pkg, cq_ctrl, cq_dp and cq_ram.
//
//   Channel   Handshake                Payload
//   request   start / busy             req_data (kind, value)
//   response  rsp_valid, one cycle     rsp_data (accepted, front, rear, empty, full)
//   register  psel/penable/pwrite      pwdata, prdata (capacity at address 0)
//
// Each word passes through the pointer update and storage write at the accepting edge,
// a read of front and rear from the storage RAM (ST_READ), the response shown (ST_RESP).
// busy stays high from the accepting edge until the response cycle ends.
// Synchronous reset sets capacity to the full depth and empties the queue; no clearing pass.
// The response cannot be held off, so nothing stalls inside the block.
module circular_queue
   import cq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req_data,
   output logic                rsp_valid,
   output rsp_type             rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready
);
   cmd_type          cmd;
   logic             cap_wr;
   logic [CAP_W-1:0] capacity;

   assign pready = 1'b1;
   assign cap_wr = psel && penable && pwrite && (paddr == REG_CAPACITY);

   always_comb begin
      unique case (paddr)
         REG_CAPACITY: prdata = DATA_W'(capacity);
         default:      prdata = '0;
      endcase
   end

   cq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   cq_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .cap_wr    (cap_wr),
      .cap_wdata (pwdata[CFG_W-1:0]),
      .capacity  (capacity),
      .rsp_data  (rsp_data)
   );

   assign rsp_valid = cmd.rsp;

endmodule

// ----- rtl/cq_ram.sv -----
// Generic RAM with one write port and two read ports, read data registered.
// Stand-alone; no package needed.
module cq_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr_a,
   input  logic [AW-1:0]        rd_addr_b,
   output logic [WIDTH-1:0]     rd_data_a,
   output logic [WIDTH-1:0]     rd_data_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- rtl/cq_ctrl.sv -----
// Controller of the circular queue: sequences update, storage read and response.
// Depends on cq_pkg.
module cq_ctrl
   import cq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output cmd_type cmd
);
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_RESP
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      rd_ff;
   logic      rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
         rd_ff    <= 1'b0;
         rsp_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_READ;
                  busy_ff  <= 1'b1;
                  rd_ff    <= 1'b1;
               end
            end
            ST_READ: begin
               state_ff <= ST_RESP;
               rd_ff    <= 1'b0;
               rsp_ff   <= 1'b1;
            end
            ST_RESP: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
               rsp_ff   <= 1'b0;
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
               rd_ff    <= 1'b0;
               rsp_ff   <= 1'b0;
            end
         endcase
      end
   end

   assign busy     = busy_ff;
   assign cmd.exec = start && !busy_ff;
   assign cmd.rd   = rd_ff;
   assign cmd.rsp  = rsp_ff;

endmodule

// ----- rtl/cq_dp.sv -----
// Datapath of the circular queue: pointers, fill state, capacity register and storage.
// Depends on cq_pkg and cq_ram.
module cq_dp
   import cq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  req_type           req_data,
   input  logic              cap_wr,
   input  logic [CFG_W-1:0]  cap_wdata,
   output logic [CAP_W-1:0]  capacity,
   output rsp_type           rsp_data
);
   typedef enum logic [1:0] {
      FILL_EMPTY,
      FILL_FULL,
      FILL_PARTIAL
   } fill_type;

   logic [CAP_W-1:0] cap_ff;
   logic [CAP_W-1:0] cap_in;
   logic [PTR_W-1:0] head_ff;
   logic [PTR_W-1:0] head_in;
   logic [PTR_W-1:0] tail_ff;
   logic [PTR_W-1:0] tail_in;
   fill_type         fill_ff;
   fill_type         fill_in;
   logic             ok_ff;
   logic             ok_in;
   logic             ram_wr;
   logic [PTR_W-1:0] head_adv;
   logic [PTR_W-1:0] tail_adv;
   logic [PTR_W-1:0] last_ptr;
   logic [DATA_W-1:0] front_raw;
   logic [DATA_W-1:0] rear_raw;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                input logic [CAP_W-1:0] cap);
      logic [PTR_W:0] n;
      begin
         n = {1'b0, p} + (PTR_W+1)'(1);
         if (32'(n) >= 32'(cap)) begin
            advance = '0;
         end else begin
            advance = n[PTR_W-1:0];
         end
      end
   endfunction

   // A written capacity of zero is taken as one, and anything above the depth as the depth.
   always_comb begin
      if (cap_wdata == '0) begin
         cap_in = CAP_W'(1);
      end else if (32'(cap_wdata) > DEPTH) begin
         cap_in = CAP_W'(DEPTH);
      end else begin
         cap_in = CAP_W'(cap_wdata);
      end
   end

   assign head_adv = advance(head_ff, cap_ff);
   assign tail_adv = advance(tail_ff, cap_ff);

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      ok_in   = 1'b1;
      ram_wr  = 1'b0;
      case (req_data.kind)
         KIND_ENQ: begin
            if (fill_ff == FILL_FULL) begin
               ok_in = 1'b0;
            end else begin
               ram_wr  = cmd.exec;
               tail_in = tail_adv;
               fill_in = (head_ff == tail_adv) ? FILL_FULL : FILL_PARTIAL;
            end
         end
         KIND_DEQ: begin
            if (fill_ff == FILL_EMPTY) begin
               ok_in = 1'b0;
            end else begin
               head_in = head_adv;
               fill_in = (head_adv == tail_ff) ? FILL_EMPTY : FILL_PARTIAL;
            end
         end
         default: begin
            ok_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= CAP_W'(DEPTH);
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= FILL_EMPTY;
         ok_ff   <= 1'b0;
      end else if (cap_wr) begin
         cap_ff  <= cap_in;
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= FILL_EMPTY;
      end else if (cmd.exec) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
         ok_ff   <= ok_in;
      end
   end

   // The newest word sits one place behind the tail, wrapping at the capacity.
   assign last_ptr = (tail_ff == '0) ? PTR_W'(cap_ff - CAP_W'(1))
                                     : tail_ff - PTR_W'(1);

   cq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ram_wr),
      .wr_addr   (tail_ff),
      .wr_data   (req_data.value),
      .rd_en     (cmd.rd),
      .rd_addr_a (head_ff),
      .rd_addr_b (last_ptr),
      .rd_data_a (front_raw),
      .rd_data_b (rear_raw)
   );

   assign capacity             = cap_ff;
   assign rsp_data.accepted    = ok_ff;
   assign rsp_data.front_value = (fill_ff == FILL_EMPTY) ? '1 : front_raw;
   assign rsp_data.rear_value  = (fill_ff == FILL_EMPTY) ? '1 : rear_raw;
   assign rsp_data.is_empty    = (fill_ff == FILL_EMPTY);
   assign rsp_data.is_full     = (fill_ff == FILL_FULL);

endmodule
